// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on the edge right after a reset cycle
`define CHK_AFTER_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) reset |=> prop) else $error(msg);

`endif

// ===== rtl/itrt_pkg.sv =====
`default_nettype none
package itrt_pkg;

   localparam logic [7:0] DEFAULT_RADIX   = 8'd10;
   localparam logic [7:0] MIN_RADIX       = 8'd2;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_ALPHA_BIAS = 8'd55;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_NUL        = 8'h00;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEP = 8;

   typedef struct packed {
      logic [31:0] value;
      logic        is_signed;
      logic [7:0]  radix;
      logic [7:0]  room;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
      logic       empty_res;
   } rsp_type;

   typedef struct packed {
      logic       negative;
      logic       tiny;
      logic [7:0] radix;
      logic [7:0] limit;
   } cmd_info_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_DIGIT,
      ST_TERM
   } back_state_type;

   function automatic logic [7:0] digit_char(input logic [7:0] d);
      return (d < DEFAULT_RADIX) ? (d + CHAR_ZERO) : (d + CHAR_ALPHA_BIAS);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/integer_to_radix_text_core.sv =====
`default_nettype none
// Integer to ASCII text converter. Each request (value, signed flag, radix, room) yields
// a minus sign for a signed negative value in radix ten, then its digits most significant
// first, cut to room - 1 characters in all, then a zero terminator flagged is_last; a room
// of 0 or 1 yields only an empty_res terminator. The front classifies requests into a
// two-entry queue; the back divides by the radix in a shared restoring divider that
// resolves 8 quotient bits per cycle and works out every digit before any is sent. The
// sign goes out in its own state after the divider, and the digit loop sees its end
// before the terminator. Results leave through a two-entry queue, so a pending result
// does not hold off new requests.
module integer_to_radix_text_core #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire itrt_pkg::req_type req_data,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      itrt_pkg::rsp_type rsp_data
);

   localparam int INFO_W = $bits(itrt_pkg::cmd_info_type);
   localparam int CMD_W  = VALUE_BITS + INFO_W;
   localparam int RSP_W  = $bits(itrt_pkg::rsp_type);

   logic                   cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [VALUE_BITS-1:0]  front_mag;
   itrt_pkg::cmd_info_type front_info, back_info;
   logic [CMD_W-1:0]       cmd_wdata, cmd_rdata;
   logic                   out_push, out_full;
   itrt_pkg::rsp_type      out_data;
   logic [RSP_W-1:0]       out_rdata;

   itrt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_mag  (front_mag),
      .cmd_info (front_info)
   );

   assign cmd_wdata = {front_mag, front_info};

   itrt_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rdata)
   );

   assign back_info = itrt_pkg::cmd_info_type'(cmd_rdata[INFO_W-1:0]);

   itrt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_mag   (cmd_rdata[CMD_W-1:INFO_W]),
      .cmd_info  (back_info),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_data  (out_data)
   );

   itrt_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_data),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_rdata)
   );

   assign rsp_data = itrt_pkg::rsp_type'(out_rdata);

endmodule
`default_nettype wire

// ===== rtl/itrt_fifo.sv =====
`default_nettype none
module itrt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output      logic             full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output      logic             empty,
   output      logic [WIDTH-1:0] rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/itrt_front.sv =====
`default_nettype none
module itrt_front #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                   req_push,
   output      logic                   req_full,
   input  wire itrt_pkg::req_type      req_data,
   output      logic                   cmd_push,
   input  wire logic                   cmd_full,
   output      logic [VALUE_BITS-1:0]  cmd_mag,
   output      itrt_pkg::cmd_info_type cmd_info
);

   logic [VALUE_BITS-1:0] mag_raw;
   logic                  negative;

   assign mag_raw  = VALUE_BITS'(req_data.value);
   // sign only for an explicit base ten
   assign negative = req_data.is_signed && (req_data.radix == itrt_pkg::DEFAULT_RADIX)
                     && mag_raw[VALUE_BITS-1];

   assign cmd_mag = negative ? (~mag_raw + VALUE_BITS'(1)) : mag_raw;

   always_comb begin
      cmd_info.negative = negative;
      cmd_info.tiny     = (req_data.room <= 8'd1);
      cmd_info.radix    = (req_data.radix < itrt_pkg::MIN_RADIX) ?
                          itrt_pkg::DEFAULT_RADIX : req_data.radix;
      cmd_info.limit    = req_data.room - 8'd1;
   end

   assign cmd_push = req_push && !cmd_full;
   assign req_full = cmd_full;

endmodule
`default_nettype wire

// ===== rtl/itrt_back.sv =====
`default_nettype none
module itrt_back #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_empty,
   output      logic                   cmd_pop,
   input  wire logic [VALUE_BITS-1:0]  cmd_mag,
   input  wire itrt_pkg::cmd_info_type cmd_info,
   output      logic                   out_push,
   input  wire logic                   out_full,
   output      itrt_pkg::rsp_type      out_data
);

   localparam int STEP    = itrt_pkg::DIV_STEP;
   localparam int DIV_CYC = (VALUE_BITS + STEP - 1) / STEP;
   localparam int PAD_W   = DIV_CYC * STEP;
   localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
   localparam int DEPTH   = VALUE_BITS;
   localparam int AW      = $clog2(DEPTH);
   localparam int PW      = $clog2(DEPTH + 1);

   itrt_pkg::back_state_type state_ff, state_in;

   logic [PAD_W-1:0] quo_ff, quo_in, quo_w;
   logic [7:0]       rem_ff, rem_in, rem_w;
   logic [8:0]       trial;
   logic [CYC_W-1:0] cyc_ff, cyc_in;
   logic [PW-1:0]    ptr_ff, ptr_in, rd_ptr;
   logic             neg_ff, neg_in;
   logic             tiny_ff, tiny_in;
   logic [7:0]       radix_ff, radix_in;
   logic [7:0]       limit_ff, limit_in;
   logic [7:0]       rd_ff;
   logic [7:0]       digit_mem [DEPTH];
   logic             mem_we;
   logic             last_cyc, quo_zero, sign_emit;

   // restoring division, STEP quotient bits per cycle
   always_comb begin
      rem_w = rem_ff;
      quo_w = quo_ff;
      trial = '0;
      for (int i = 0; i < STEP; i++) begin
         trial = {rem_w, quo_w[PAD_W-1]};
         quo_w = {quo_w[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial    = trial - {1'b0, radix_ff};
            quo_w[0] = 1'b1;
         end
         rem_w = trial[7:0];
      end
   end

   assign last_cyc  = (cyc_ff == CYC_W'(DIV_CYC - 1));
   assign quo_zero  = (quo_w == '0);
   assign sign_emit = neg_ff && (limit_ff != 8'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itrt_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = cmd_info.tiny ? itrt_pkg::ST_TERM : itrt_pkg::ST_DIV;
            end
         end
         itrt_pkg::ST_DIV: begin
            if (last_cyc && quo_zero) begin
               state_in = itrt_pkg::ST_SIGN;
            end
         end
         itrt_pkg::ST_SIGN: begin
            if (!sign_emit || !out_full) begin
               state_in = itrt_pkg::ST_DIGIT;
            end
         end
         itrt_pkg::ST_DIGIT: begin
            if ((ptr_ff == '0) || (limit_ff == 8'd0)) begin
               state_in = itrt_pkg::ST_TERM;
            end
         end
         itrt_pkg::ST_TERM: begin
            if (!out_full) begin
               state_in = itrt_pkg::ST_IDLE;
            end
         end
         default: state_in = itrt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop            = 1'b0;
      out_push           = 1'b0;
      out_data.character = itrt_pkg::CHAR_NUL;
      out_data.is_last   = 1'b0;
      out_data.empty_res = 1'b0;
      mem_we             = 1'b0;
      quo_in             = quo_ff;
      rem_in             = rem_ff;
      cyc_in             = cyc_ff;
      ptr_in             = ptr_ff;
      neg_in             = neg_ff;
      tiny_in            = tiny_ff;
      radix_in           = radix_ff;
      limit_in           = limit_ff;
      case (state_ff)
         itrt_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               quo_in   = PAD_W'(cmd_mag);
               rem_in   = '0;
               cyc_in   = '0;
               ptr_in   = '0;
               neg_in   = cmd_info.negative;
               tiny_in  = cmd_info.tiny;
               radix_in = cmd_info.radix;
               limit_in = cmd_info.limit;
            end
         end
         itrt_pkg::ST_DIV: begin
            quo_in = quo_w;
            rem_in = rem_w;
            if (last_cyc) begin
               // digit done, quotient stays as next dividend
               mem_we = 1'b1;
               ptr_in = ptr_ff + PW'(1);
               rem_in = '0;
               cyc_in = '0;
            end else begin
               cyc_in = cyc_ff + CYC_W'(1);
            end
         end
         itrt_pkg::ST_SIGN: begin
            if (sign_emit && !out_full) begin
               out_push           = 1'b1;
               out_data.character = itrt_pkg::CHAR_MINUS;
               limit_in           = limit_ff - 8'd1;
            end
         end
         itrt_pkg::ST_DIGIT: begin
            if ((ptr_ff != '0) && (limit_ff != 8'd0) && !out_full) begin
               out_push           = 1'b1;
               out_data.character = rd_ff;
               ptr_in             = ptr_ff - PW'(1);
               limit_in           = limit_ff - 8'd1;
            end
         end
         itrt_pkg::ST_TERM: begin
            if (!out_full) begin
               out_push           = 1'b1;
               out_data.is_last   = 1'b1;
               out_data.empty_res = tiny_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // read the top of the digit stack for the pointer of the next cycle
   assign rd_ptr = ptr_in - PW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[ptr_ff[AW-1:0]] <= itrt_pkg::digit_char(rem_w);
      end
      rd_ff <= digit_mem[rd_ptr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrt_pkg::ST_IDLE;
         cyc_ff   <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cyc_ff   <= cyc_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      tiny_ff  <= tiny_in;
      radix_ff <= radix_in;
      limit_ff <= limit_in;
   end

endmodule
`default_nettype wire

// ===== rtl/itrt_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module itrt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire itrt_pkg::rsp_type rsp_data
);

   // both queues drain on reset
   `CHK_AFTER_RESET(a_rsp_empty_after_reset, rsp_empty, "result queue not empty after reset")
   `CHK_AFTER_RESET(a_req_open_after_reset, !req_full, "request side full after reset")

   // an empty conversion is a single terminator
   `CHK_ALWAYS(a_empty_is_last, (!rsp_empty && rsp_data.empty_res) |-> rsp_data.is_last, "empty_res without is_last")
   `CHK_ALWAYS(a_last_is_nul, (!rsp_empty && rsp_data.is_last) |-> (rsp_data.character == 8'h00), "terminator character not zero")

   `CHK_ALWAYS(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "waiting result changed")

endmodule

bind integer_to_radix_text_core itrt_checker u_itrt_checker (.*);
`default_nettype wire
